FILE: hdl/mstt_pkg.sv
package mstt_pkg;

    // Command codes carried in the input beat's tuser
    localparam logic [2:0] FN_TICK    = 3'd0;
    localparam logic [2:0] FN_START   = 3'd1;
    localparam logic [2:0] FN_RESTART = 3'd2;
    localparam logic [2:0] FN_STOP    = 3'd3;
    localparam logic [2:0] FN_REBASE  = 3'd4;
    localparam logic [2:0] FN_RELEASE = 3'd5;

    // Register map of the configuration port
    localparam int         ADDR_W      = 3;
    localparam logic       REG_TPM_IDX = 1'b0;
    localparam logic [15:0] TPM_RESET  = 16'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REBASE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // Write request into the slot store
    typedef struct packed {
        logic        st_we;    // write start tick
        logic        to_we;    // write timeout and id, mark entry valid
        logic        to_clr;   // drop timeout and id back to zero
        logic [31:0] start;
        logic [31:0] timeout;
        logic [7:0]  id;
    } store_wr_t;

endpackage

FILE: hdl/mstt_store.sv
module mstt_store
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = 8,
    parameter int IDX_W     = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  store_wr_t        wr,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_start,
    output logic [31:0]      rd_timeout,
    output logic [7:0]       rd_id
);

    logic [31:0]          start_mem [NUM_SLOTS];
    logic [39:0]          to_mem    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] to_vld_reg;
    logic [31:0]          rd_start_reg;
    logic [39:0]          rd_to_reg;
    logic                 rd_vld_reg;

    // Write ports
    always_ff @(posedge aclk) begin
        if (wr.st_we) begin
            start_mem[wr_addr] <= wr.start;
        end
        if (wr.to_we) begin
            to_mem[wr_addr] <= {wr.timeout, wr.id};
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_start_reg <= start_mem[rd_addr];
            rd_to_reg    <= to_mem[rd_addr];
        end
    end

    // Track which timeout entries hold written data; others read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            to_vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.to_we) begin
                to_vld_reg[wr_addr] <= 1'b1;
            end else if (wr.to_clr) begin
                to_vld_reg[wr_addr] <= 1'b0;
            end
            if (rd_en) begin
                rd_vld_reg <= to_vld_reg[rd_addr];
            end
        end
    end

    assign rd_start   = rd_start_reg;
    assign rd_timeout = rd_vld_reg ? rd_to_reg[39:8] : 32'd0;
    assign rd_id      = rd_vld_reg ? rd_to_reg[7:0]  : 8'd0;

endmodule

FILE: hdl/multi_slot_timeout_timer.sv
// Commands other than tick and rebase complete in idle; the next beat can follow at once.
// Rebase sweeps the start-tick memory; no new beat is taken until the sweep ends.
// Tick reads one slot per cycle from the slot store, except while the result register
// is held by m_tready low. The first result goes out when a second slot fires, else at the
// end of the scan; no new beat is taken until the scan ends.
// Synchronous active-low reset clears all slots, ticks_per_ms to 1, and empties the output.
module multi_slot_timeout_timer
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input beats
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,  // slot[2:0], now_ticks[34:3], timer_id[42:35],
                                        // duration_ms[58:43], zero fill
    input  logic [2:0]        s_tuser,  // func[2:0]
    // result beats
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,  // fired_slot[2:0], fired_id[10:3], zero fill
    output logic              m_tlast,  // last
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(NUM_SLOTS);

    state_t               state_reg, state_next;
    logic [15:0]          tpm_reg;
    logic [NUM_SLOTS-1:0] running_reg, running_next;
    logic [31:0]          now_reg, now_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 p1_vld_reg, p1_vld_next;
    logic [IDX_W-1:0]     p1_idx_reg, p1_idx_next;
    logic                 hold_vld_reg, hold_vld_next;
    logic [2:0]           hold_slot_reg, hold_slot_next;
    logic [7:0]           hold_id_reg, hold_id_next;
    logic                 out_vld_reg, out_vld_next;
    logic [2:0]           out_slot_reg, out_slot_next;
    logic [7:0]           out_id_reg, out_id_next;
    logic                 out_last_reg, out_last_next;

    logic [2:0]           in_func;
    logic [2:0]           in_slot;
    logic [31:0]          in_now;
    logic [7:0]           in_id;
    logic [15:0]          in_dur;
    logic                 slot_ok;
    logic [IDX_W-1:0]     slot_idx;
    logic [IDX_W-1:0]     cur_idx;

    store_wr_t            wr;
    logic [IDX_W-1:0]     wr_addr;
    logic                 rd_en;
    logic [31:0]          rd_start;
    logic [31:0]          rd_timeout;
    logic [7:0]           rd_id;

    logic [31:0]          elapsed;
    logic                 hit;
    logic                 out_free;
    logic                 push;
    logic                 stall;
    logic                 issue;
    logic                 cfg_wr;

    // Unpack the input beat
    assign in_func  = s_tuser;
    assign in_slot  = s_tdata[2:0];
    assign in_now   = s_tdata[34:3];
    assign in_id    = s_tdata[42:35];
    assign in_dur   = s_tdata[58:43];
    assign slot_ok  = int'(in_slot) < NUM_SLOTS;
    assign slot_idx = IDX_W'(in_slot);
    assign cur_idx  = rd_idx_reg[IDX_W-1:0];

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg <= TPM_RESET;
        end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_TPM_IDX) begin
            tpm_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[ADDR_W-1:2] == REG_TPM_IDX) begin
            prdata = {16'd0, tpm_reg};
        end
    end

    // Slot store
    mstt_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .rd_en      (rd_en),
        .rd_addr    (cur_idx),
        .rd_start   (rd_start),
        .rd_timeout (rd_timeout),
        .rd_id      (rd_id)
    );

    // Expiry check on the slot held in the read register
    assign elapsed  = now_reg - rd_start;
    assign hit      = p1_vld_reg && running_reg[p1_idx_reg] && (elapsed >= rd_timeout);
    assign out_free = !out_vld_reg || m_tready;
    assign push     = hit && hold_vld_reg;
    assign stall    = push && !out_free;
    assign issue    = rd_idx_reg != SLOT_CNT;

    // Sequencer: commands, rebase sweep, tick scan
    always_comb begin
        state_next     = state_reg;
        running_next   = running_reg;
        now_next       = now_reg;
        rd_idx_next    = rd_idx_reg;
        p1_vld_next    = p1_vld_reg;
        p1_idx_next    = p1_idx_reg;
        hold_vld_next  = hold_vld_reg;
        hold_slot_next = hold_slot_reg;
        hold_id_next   = hold_id_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_slot_next  = out_slot_reg;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;
        wr             = '0;
        wr_addr        = slot_idx;
        rd_en          = 1'b0;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    now_next = in_now;
                    case (in_func)
                        FN_TICK: begin
                            rd_idx_next = '0;
                            state_next  = ST_SCAN;
                        end
                        FN_START: begin
                            if (slot_ok) begin
                                wr.st_we   = 1'b1;
                                wr.to_we   = 1'b1;
                                wr.start   = in_now;
                                wr.timeout = {16'd0, in_dur} * {16'd0, tpm_reg};
                                wr.id      = in_id;
                                running_next[slot_idx] = 1'b1;
                            end
                        end
                        FN_RESTART: begin
                            if (slot_ok) begin
                                wr.st_we = 1'b1;
                                wr.start = in_now;
                                running_next[slot_idx] = 1'b1;
                            end
                        end
                        FN_STOP: begin
                            if (slot_ok) begin
                                running_next[slot_idx] = 1'b0;
                            end
                        end
                        FN_REBASE: begin
                            rd_idx_next = '0;
                            state_next  = ST_REBASE;
                        end
                        FN_RELEASE: begin
                            if (slot_ok) begin
                                wr.st_we  = 1'b1;
                                wr.to_clr = 1'b1;
                                running_next[slot_idx] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_REBASE: begin
                // Move the start of each running slot to now, one slot a cycle
                if (issue) begin
                    wr.st_we    = running_reg[cur_idx];
                    wr.start    = now_reg;
                    wr_addr     = cur_idx;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN: begin
                // Read one slot a cycle unless the output stalls; hold the newest hit until the next one
                // shows it is not the last
                if (!stall) begin
                    rd_en       = issue;
                    p1_vld_next = issue;
                    p1_idx_next = cur_idx;
                    if (issue) begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                    if (hit) begin
                        hold_vld_next  = 1'b1;
                        hold_slot_next = 3'(p1_idx_reg);
                        hold_id_next   = rd_id;
                    end
                    if (push) begin
                        out_vld_next  = 1'b1;
                        out_slot_next = hold_slot_reg;
                        out_id_next   = hold_id_reg;
                        out_last_next = 1'b0;
                    end
                end
                if (!issue && !p1_vld_reg) begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                // Send the held hit as the last beat of the tick
                if (!hold_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_slot_next = hold_slot_reg;
                    out_id_next   = hold_id_reg;
                    out_last_next = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            running_reg  <= '0;
            rd_idx_reg   <= '0;
            p1_vld_reg   <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            rd_idx_reg   <= rd_idx_next;
            p1_vld_reg   <= p1_vld_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        now_reg       <= now_next;
        p1_idx_reg    <= p1_idx_next;
        hold_slot_reg <= hold_slot_next;
        hold_id_reg   <= hold_id_next;
        out_slot_reg  <= out_slot_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_id_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // A tick never returns to idle with an unsent hit
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !hold_vld_reg)
        else $error("held hit left over in idle");

    // The read pipeline is only live during a scan
    a_p1_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_vld_reg |-> state_reg == ST_SCAN)
        else $error("slot read in flight outside scan");

    // The slot counter never runs past the bank
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_idx_reg <= SLOT_CNT)
        else $error("slot counter out of range");

    // A stalled scan keeps its pending slot and counter
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && stall |=> p1_vld_reg && $stable(rd_idx_reg))
        else $error("scan advanced during stall");
`endif

endmodule

FILE: tb/timer_expiry_checker.sv
`timescale 1ns / 1ps
module timer_expiry_checker
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [63:0]       s_tdata,  // slot[2:0], now_ticks[34:3], timer_id[42:35],
                                        // duration_ms[58:43], zero fill
    input  logic [2:0]        s_tuser,  // func[2:0]
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [15:0]       m_tdata,  // fired_slot[2:0], fired_id[10:3], zero fill
    input  logic              m_tlast,  // last
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                fault_count,
    output int                fires_due,
    output int                fires_checked
);

    typedef struct packed {
        logic [2:0] slot;
        logic [7:0] id;
        logic       last;
    } expiry_t;

    logic [15:0] scale;
    logic        slot_running [NUM_SLOTS];
    logic [31:0] slot_start   [NUM_SLOTS];
    logic [31:0] slot_timeout [NUM_SLOTS];
    logic [7:0]  slot_tag     [NUM_SLOTS];
    expiry_t     expiry_q [$];
    int          faults = 0;
    int          checked = 0;

    // Update the slot bank for one command; a tick queues its expiries in slot order
    task automatic apply_command(input logic [2:0] fn, input logic [2:0] slot,
                                 input logic [31:0] now, input logic [7:0] id,
                                 input logic [15:0] dur);
        expiry_t     hits [$];
        expiry_t     hit;
        logic [31:0] elapsed;
        logic        slot_ok;
        slot_ok = int'(slot) < NUM_SLOTS;
        case (fn)
            FN_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    elapsed = now - slot_start[i];
                    if (slot_running[i] && elapsed >= slot_timeout[i]) begin
                        hit.slot = 3'(i);
                        hit.id   = slot_tag[i];
                        hit.last = 1'b0;
                        hits.push_back(hit);
                    end
                end
                if (hits.size() > 0)
                    hits[hits.size() - 1].last = 1'b1;
                foreach (hits[k])
                    expiry_q.push_back(hits[k]);
            end
            FN_START: begin
                if (slot_ok) begin
                    slot_timeout[slot] = 32'(dur) * 32'(scale);
                    slot_start[slot]   = now;
                    slot_tag[slot]     = id;
                    slot_running[slot] = 1'b1;
                end
            end
            FN_RESTART: begin
                if (slot_ok) begin
                    slot_start[slot]   = now;
                    slot_running[slot] = 1'b1;
                end
            end
            FN_STOP: begin
                if (slot_ok)
                    slot_running[slot] = 1'b0;
            end
            FN_REBASE: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_running[i])
                        slot_start[i] = now;
            end
            FN_RELEASE: begin
                if (slot_ok) begin
                    slot_running[slot] = 1'b0;
                    slot_start[slot]   = '0;
                    slot_timeout[slot] = '0;
                    slot_tag[slot]     = '0;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        expiry_t want;
        if (!aresetn) begin
            scale = TPM_RESET;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_running[i] = 1'b0;
                slot_start[i]   = '0;
                slot_timeout[i] = '0;
                slot_tag[i]     = '0;
            end
            expiry_q.delete();
        end else begin
            // Track register writes and check read-back
            if (psel && penable && pready && (paddr[ADDR_W-1:2] == REG_TPM_IDX)) begin
                if (pwrite) begin
                    scale = pwdata[15:0];
                end else if (prdata != {16'h0, scale}) begin
                    $error("ticks_per_ms mismatch: expected %0d, actual %0d", scale, prdata);
                    faults++;
                end
            end

            // Predict on every accepted command beat
            if (s_tvalid && s_tready)
                apply_command(s_tuser, s_tdata[2:0], s_tdata[34:3], s_tdata[42:35],
                              s_tdata[58:43]);

            // Compare each accepted expiry beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expiry_q.size() == 0) begin
                    $error("unexpected expiry beat: slot %0d id %0d last %0d",
                           m_tdata[2:0], m_tdata[10:3], m_tlast);
                    faults++;
                end else begin
                    want = expiry_q.pop_front();
                    checked++;
                    if (m_tdata[2:0] != want.slot) begin
                        $error("fired_slot mismatch: expected %0d, actual %0d",
                               want.slot, m_tdata[2:0]);
                        faults++;
                    end
                    if (m_tdata[10:3] != want.id) begin
                        $error("fired_id mismatch: expected %0d, actual %0d",
                               want.id, m_tdata[10:3]);
                        faults++;
                    end
                    if (m_tlast != want.last) begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
                        faults++;
                    end
                end
            end
        end
        fault_count   <= faults;
        fires_due     <= expiry_q.size();
        fires_checked <= checked;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mstt_pkg::*;

    localparam int NUM_SLOTS   = 8;
    localparam int SETTLE      = 24;    // margin for a tick scan to finish
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_CMDS  = 58;
    localparam int NUM_PHASES  = 5;
    localparam int PRESSURE_PHASE = 1;

    // Command codes the block treats as no-ops
    localparam logic [2:0] FN_SPARE_LO = 3'd6;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]  fn;
        logic [2:0]  slot;
        logic [31:0] now;
        logic [7:0]  id;
        logic [15:0] dur;
    } command_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata  = '0;   // slot[2:0], now_ticks[34:3], timer_id[42:35],
                                        // duration_ms[58:43], zero fill
    logic [2:0]        s_tuser  = FN_TICK;  // func[2:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;         // fired_slot[2:0], fired_id[10:3], zero fill
    logic              m_tlast;         // last
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    int          faults;
    int          fires_due;
    int          fires_checked;
    command_t    cmd_q [$];
    logic [31:0] tick_now   = '0;
    logic [15:0] scale_now  = TPM_RESET;
    logic [15:0] scale_plan [NUM_PHASES] = '{16'hFFFF, 16'h0000, 16'd3, 16'd1, 16'd100};
    int          burst_left = 0;
    int          cmds_sent  = 0;
    logic        hold_req   = 1'b0;
    int          hold_cnt   = 0;
    int          rx_mode    = 0;
    int          rx_left    = 0;
    int          idle_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    multi_slot_timeout_timer #(.NUM_SLOTS(NUM_SLOTS)) dut (.*);

    timer_expiry_checker #(.NUM_SLOTS(NUM_SLOTS)) checker_i (
        .*,
        .fault_count  (faults),
        .fires_due    (fires_due),
        .fires_checked(fires_checked)
    );

    // Receiver: one long hold-off on request, otherwise a changing stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(4, 40);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [2:0] fn, input logic [2:0] slot,
                             input logic [31:0] now, input logic [7:0] id,
                             input logic [15:0] dur);
        command_t c;
        c.fn   = fn;
        c.slot = slot;
        c.now  = now;
        c.id   = id;
        c.dur  = dur;
        cmd_q.push_back(c);
    endtask

    // Stream queued commands in bursts with random gaps
    task automatic send_commands();
        command_t c;
        int       gap;
        while (cmd_q.size() > 0) begin
            c = cmd_q.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
            end
            burst_left--;
            s_tvalid <= 1'b1;
            s_tuser  <= c.fn;
            s_tdata  <= {5'b0, c.dur, c.id, c.now, c.slot};
            do @(posedge aclk); while (!s_tready);
            cmds_sent++;
        end
        s_tvalid <= 1'b0;
    endtask

    // Wait out every predicted expiry, then let a tick with no expiry finish its scan
    task automatic settle();
        do @(posedge aclk); while (fires_due != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // One configuration transfer: setup cycle, access until pready, then idle
    task automatic access_scale(input logic wr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({REG_TPM_IDX, 2'b00});
        pwdata  <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (wr)
            scale_now = value;
    endtask

    // Random commands: mostly starts and ticks on an advancing clock, some noise
    task automatic queue_random(input int count);
        int          pick;
        int          dsel;
        logic [2:0]  fn;
        logic [2:0]  slot;
        logic [15:0] dur;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            slot = 3'($urandom_range(0, NUM_SLOTS - 1));
            if (pick < 3)
                tick_now = $urandom();
            else
                tick_now = tick_now + $urandom_range(0, 3) * scale_now + $urandom_range(0, 3);
            dsel = $urandom_range(0, 19);
            if (dsel == 0)
                dur = 16'h0000;
            else if (dsel == 1)
                dur = 16'hFFFF;
            else if (dsel < 4)
                dur = 16'($urandom());
            else
                dur = 16'($urandom_range(1, 6));
            if (pick < 40)
                fn = FN_TICK;
            else if (pick < 62)
                fn = FN_START;
            else if (pick < 70)
                fn = FN_RESTART;
            else if (pick < 80)
                fn = FN_STOP;
            else if (pick < 85)
                fn = FN_REBASE;
            else if (pick < 92)
                fn = FN_RELEASE;
            else
                fn = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
            if (fn >= FN_SPARE_LO)
                queue_cmd(fn, slot, $urandom(), 8'($urandom()), 16'($urandom()));
            else
                queue_cmd(fn, slot, tick_now, 8'($urandom_range(0, 255)), dur);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Read back the reset scale, then run the directed cases at that scale
        access_scale(1'b0, 16'h0);
        queue_cmd(FN_TICK,    3'd0, 32'h0000_0000, 8'h00, 16'd1);     // nothing running
        queue_cmd(FN_START,   3'd0, 32'hFFFF_FFFF, 8'h00, 16'hFFFF);
        queue_cmd(FN_START,   3'd7, 32'hFFFF_FFFE, 8'hFF, 16'd1);
        queue_cmd(FN_START,   3'd3, 32'h0000_0005, 8'hA5, 16'd0);     // zero duration
        queue_cmd(FN_TICK,    3'd0, 32'hFFFF_FFFF, 8'h00, 16'd1);
        queue_cmd(FN_TICK,    3'd0, 32'h0000_FFFE, 8'h00, 16'd1);     // elapsed across wrap
        queue_cmd(FN_STOP,    3'd3, 32'h0000_FFFE, 8'h00, 16'd1);
        queue_cmd(FN_STOP,    3'd3, 32'h0000_FFFE, 8'h00, 16'd1);     // already idle
        queue_cmd(FN_SPARE_LO, 3'd6, 32'hDEAD_BEEF, 8'h3C, 16'h1234);
        queue_cmd(FN_SPARE_HI, 3'd1, 32'h5555_AAAA, 8'hC3, 16'hEDCB);
        queue_cmd(FN_REBASE,  3'd5, 32'h1234_5678, 8'h00, 16'd1);     // slot field ignored
        queue_cmd(FN_TICK,    3'd0, 32'h1234_5678, 8'h00, 16'd1);
        queue_cmd(FN_RELEASE, 3'd7, 32'h1234_5678, 8'h00, 16'd1);
        queue_cmd(FN_RESTART, 3'd7, 32'h1234_5679, 8'h00, 16'd1);     // after release
        queue_cmd(FN_RESTART, 3'd2, 32'h1234_5679, 8'h00, 16'd1);     // never started
        queue_cmd(FN_TICK,    3'd0, 32'h1234_5679, 8'h00, 16'd1);
        for (int i = 0; i < NUM_SLOTS; i++)
            queue_cmd(FN_START, 3'(i), $urandom(), 8'(i * 37 + 1), 16'd0);
        queue_cmd(FN_TICK,    3'd0, 32'hFFFF_FFFF, 8'h00, 16'd1);     // every slot fires
        send_commands();
        settle();

        // Random phases, one scale setting each
        scale_plan[NUM_PHASES - 1] = 16'($urandom_range(2, 1000));
        tick_now = $urandom();
        for (int p = 0; p < NUM_PHASES; p++) begin
            access_scale(1'b1, scale_plan[p]);
            access_scale(1'b0, 16'h0);
            if (p == PRESSURE_PHASE) begin
                // Hold the result side while every slot keeps firing
                hold_req <= 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++)
                    queue_cmd(FN_RESTART, 3'(i), tick_now, 8'h00, 16'd1);
            end
            queue_random(PHASE_CMDS);
            send_commands();
            settle();
        end

        $display("Run covered %0d commands at the reset scale and %0d programmed scales",
                 cmds_sent, NUM_PHASES);
        $display("including 0 and 65535; %0d expiry beats compared, one long output stall.",
                 fires_checked);
        if (faults == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
